// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the offset/scale averaging block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define AOSMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define AOSMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/aosma_pkg.sv =====
// ----------------------------------------------------------------------------
// aosma_pkg
// types and constants of the adc offset, scale and moving average block
// ----------------------------------------------------------------------------
package aosma_pkg;

   localparam int NUM_CH          = 6;
   localparam int CODE_W          = 12;
   localparam int GAIN_W          = 24;
   localparam int PROD_W          = CODE_W + GAIN_W;
   localparam int RND_SHIFT       = 8;
   localparam int SCALE_W         = PROD_W - RND_SHIFT;
   localparam int SAMPLE_W        = SCALE_W + 1;
   localparam int OUT_W           = 32;
   localparam int DIV_BITS        = 8;
   localparam int WINDOW_TAPS_DEF = 5;

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_AC_GAIN   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DC_GAIN   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CURR_GAIN = 2'd2;

   localparam logic [GAIN_W-1:0] AC_GAIN_RST   = 24'd380850;
   localparam logic [GAIN_W-1:0] DC_GAIN_RST   = 24'd270402;
   localparam logic [GAIN_W-1:0] CURR_GAIN_RST = 24'd1803;

   // channel order of the lanes
   localparam int CH_VOFF = 0;
   localparam int CH_VAC  = 1;
   localparam int CH_VDC  = 2;
   localparam int CH_IOFF = 3;
   localparam int CH_IAC  = 4;
   localparam int CH_ISP  = 5;

   typedef struct packed {
      logic [CODE_W-1:0] volt_offset_code;
      logic [CODE_W-1:0] volt_ac_code;
      logic [CODE_W-1:0] volt_dc_code;
      logic [CODE_W-1:0] curr_offset_code;
      logic [CODE_W-1:0] curr_ac_code;
      logic [CODE_W-1:0] curr_spare_code;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] volt_offset_avg;
      logic signed [OUT_W-1:0] volt_ac_avg;
      logic signed [OUT_W-1:0] volt_dc_avg;
      logic signed [OUT_W-1:0] curr_offset_avg;
      logic signed [OUT_W-1:0] curr_ac_avg;
      logic signed [OUT_W-1:0] curr_spare_avg;
   } rsp_type;

   // per-cycle strobes from the sequencer to every lane
   typedef struct packed {
      logic capture;
      logic sample;
      logic accum;
      logic prep;
      logic div;
   } lane_ctl_type;

   // what one lane hands to the merge stage
   typedef struct packed {
      logic                neg;
      logic [SAMPLE_W-1:0] mag;
   } lane_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_ACCUM,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/adc_offset_scale_moving_average.sv =====
// ----------------------------------------------------------------------------
// adc_offset_scale_moving_average
// six-channel adc scaling, offset correction and boxcar moving average
// ----------------------------------------------------------------------------
// sequence: an item is captured and scaled, offset-corrected, added to the running
//   sum, set up for the divide, divided digit by digit and moved to the output register
// pacing: a new item is taken only once the last has left the per-lane digit divider
// reset: running sums, fill count, write slot and output valid clear at once;
//   gains return to defaults; history is masked by the fill count, not cleared
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_offset_scale_moving_average #(
   parameter int WINDOW_TAPS = aosma_pkg::WINDOW_TAPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  aosma_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output aosma_pkg::rsp_type                  rsp_data,
   input  logic                                csr_we,
   input  logic [aosma_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [aosma_pkg::GAIN_W-1:0]        csr_wdata
);

   localparam int SLOT_W = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;
   localparam int CNT_W  = $clog2(WINDOW_TAPS + 1);
   localparam int SUM_W  = aosma_pkg::SAMPLE_W + $clog2(WINDOW_TAPS);
   localparam int NW     = SUM_W + 1;
   localparam int NDIG   = (NW + aosma_pkg::DIV_BITS - 1) / aosma_pkg::DIV_BITS;
   localparam int DIG_W  = (NDIG > 1) ? $clog2(NDIG) : 1;

   // configuration registers
   logic [aosma_pkg::GAIN_W-1:0] ac_gain_ff;
   logic [aosma_pkg::GAIN_W-1:0] dc_gain_ff;
   logic [aosma_pkg::GAIN_W-1:0] curr_gain_ff;

   // sequencer and window bookkeeping
   aosma_pkg::state_type state_ff;
   aosma_pkg::state_type state_in;
   logic [DIG_W-1:0]     dig_ff;
   logic [DIG_W-1:0]     dig_in;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    slot_in;
   logic [CNT_W-1:0]     fill_ff;
   logic [CNT_W-1:0]     fill_in;

   logic                     accept;
   logic                     merge_free;
   logic                     merge_load;
   aosma_pkg::lane_ctl_type  lane_ctl;
   logic                     hist_live;

   logic [aosma_pkg::CODE_W-1:0]          code_arr   [aosma_pkg::NUM_CH];
   logic [aosma_pkg::GAIN_W-1:0]          gain_arr   [aosma_pkg::NUM_CH];
   logic [aosma_pkg::SCALE_W-1:0]         scaled_arr [aosma_pkg::NUM_CH];
   logic signed [aosma_pkg::SAMPLE_W-1:0] samp_arr   [aosma_pkg::NUM_CH];
   aosma_pkg::lane_res_type               res_arr    [aosma_pkg::NUM_CH];

   // gain registers, writes to unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         ac_gain_ff   <= aosma_pkg::AC_GAIN_RST;
         dc_gain_ff   <= aosma_pkg::DC_GAIN_RST;
         curr_gain_ff <= aosma_pkg::CURR_GAIN_RST;
      end else if (csr_we) begin
         case (csr_addr)
            aosma_pkg::CSR_AC_GAIN:   ac_gain_ff   <= csr_wdata;
            aosma_pkg::CSR_DC_GAIN:   dc_gain_ff   <= csr_wdata;
            aosma_pkg::CSR_CURR_GAIN: curr_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // new item taken when idle, or when the finished one moves to the output register
   assign req_stall  = !((state_ff == aosma_pkg::ST_IDLE) ||
                         ((state_ff == aosma_pkg::ST_DONE) && merge_free));
   assign accept     = req_valid && !req_stall;
   assign merge_load = (state_ff == aosma_pkg::ST_DONE) && merge_free;

   // slots past the fill count were never written since reset
   assign hist_live = (fill_ff == CNT_W'(WINDOW_TAPS));

   assign lane_ctl.capture = accept;
   assign lane_ctl.sample  = (state_ff == aosma_pkg::ST_SAMPLE);
   assign lane_ctl.accum   = (state_ff == aosma_pkg::ST_ACCUM);
   assign lane_ctl.prep    = (state_ff == aosma_pkg::ST_PREP);
   assign lane_ctl.div     = (state_ff == aosma_pkg::ST_DIV);

   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      slot_in  = slot_ff;
      fill_in  = fill_ff;
      case (state_ff)
         aosma_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = aosma_pkg::ST_SAMPLE;
            end
         end
         aosma_pkg::ST_SAMPLE: begin
            state_in = aosma_pkg::ST_ACCUM;
         end
         aosma_pkg::ST_ACCUM: begin
            // window advances with the history write
            state_in = aosma_pkg::ST_PREP;
            slot_in  = (slot_ff == SLOT_W'(WINDOW_TAPS - 1)) ? '0 : slot_ff + SLOT_W'(1);
            if (fill_ff != CNT_W'(WINDOW_TAPS)) begin
               fill_in = fill_ff + CNT_W'(1);
            end
         end
         aosma_pkg::ST_PREP: begin
            state_in = aosma_pkg::ST_DIV;
            dig_in   = '0;
         end
         aosma_pkg::ST_DIV: begin
            if (dig_ff == DIG_W'(NDIG - 1)) begin
               state_in = aosma_pkg::ST_DONE;
            end else begin
               dig_in = dig_ff + DIG_W'(1);
            end
         end
         aosma_pkg::ST_DONE: begin
            if (accept) begin
               state_in = aosma_pkg::ST_SAMPLE;
            end else if (merge_load) begin
               state_in = aosma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aosma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aosma_pkg::ST_IDLE;
         dig_ff   <= '0;
         slot_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dig_ff   <= dig_in;
         slot_ff  <= slot_in;
         fill_ff  <= fill_in;
      end
   end

   // unpack the item and pick each channel's gain group
   assign code_arr[aosma_pkg::CH_VOFF] = req_data.volt_offset_code;
   assign code_arr[aosma_pkg::CH_VAC]  = req_data.volt_ac_code;
   assign code_arr[aosma_pkg::CH_VDC]  = req_data.volt_dc_code;
   assign code_arr[aosma_pkg::CH_IOFF] = req_data.curr_offset_code;
   assign code_arr[aosma_pkg::CH_IAC]  = req_data.curr_ac_code;
   assign code_arr[aosma_pkg::CH_ISP]  = req_data.curr_spare_code;

   assign gain_arr[aosma_pkg::CH_VOFF] = ac_gain_ff;
   assign gain_arr[aosma_pkg::CH_VAC]  = ac_gain_ff;
   assign gain_arr[aosma_pkg::CH_VDC]  = dc_gain_ff;
   assign gain_arr[aosma_pkg::CH_IOFF] = curr_gain_ff;
   assign gain_arr[aosma_pkg::CH_IAC]  = curr_gain_ff;
   assign gain_arr[aosma_pkg::CH_ISP]  = curr_gain_ff;

   // offset corrections; 28-bit scaled values cannot leave the 32-bit range
   assign samp_arr[aosma_pkg::CH_VOFF] = $signed({1'b0, scaled_arr[aosma_pkg::CH_VOFF]});
   assign samp_arr[aosma_pkg::CH_VAC]  = $signed({1'b0, scaled_arr[aosma_pkg::CH_VOFF]})
                                       - $signed({1'b0, scaled_arr[aosma_pkg::CH_VAC]});
   assign samp_arr[aosma_pkg::CH_VDC]  = $signed({1'b0, scaled_arr[aosma_pkg::CH_VDC]});
   assign samp_arr[aosma_pkg::CH_IOFF] = $signed({1'b0, scaled_arr[aosma_pkg::CH_IOFF]});
   assign samp_arr[aosma_pkg::CH_IAC]  = $signed({1'b0, scaled_arr[aosma_pkg::CH_IAC]})
                                       - $signed({1'b0, scaled_arr[aosma_pkg::CH_IOFF]});
   assign samp_arr[aosma_pkg::CH_ISP]  = $signed({1'b0, scaled_arr[aosma_pkg::CH_ISP]})
                                       - $signed({1'b0, scaled_arr[aosma_pkg::CH_IOFF]});

   // six parallel lanes: scaler in front, window and divider behind
   for (genvar k = 0; k < aosma_pkg::NUM_CH; k++) begin : g_lane
      aosma_scale u_scale (
         .clock  (clock),
         .load   (accept),
         .code   (code_arr[k]),
         .gain   (gain_arr[k]),
         .scaled (scaled_arr[k])
      );

      aosma_lane #(
         .WINDOW_TAPS (WINDOW_TAPS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (lane_ctl),
         .sample    (samp_arr[k]),
         .slot      (slot_ff),
         .hist_live (hist_live),
         .count     (fill_ff),
         .res       (res_arr[k])
      );
   end

   // merge the lane results into the output register
   aosma_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (merge_load),
      .lane_res  (res_arr),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (merge_free)
   );

   // items enter only when the sequencer is free
   `AOSMA_ASSERT_SAME(a_accept_free, clock, reset, req_valid && !req_stall,
      state_ff == aosma_pkg::ST_IDLE || state_ff == aosma_pkg::ST_DONE, "accept while busy")
   // a new result appears only out of the done state
   `AOSMA_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid),
      $past(state_ff == aosma_pkg::ST_DONE), "result without finished item")
   // during warm-up the write slot tracks the fill count
   `AOSMA_ASSERT_SAME(a_warm_slot, clock, reset, fill_ff != CNT_W'(WINDOW_TAPS),
      CNT_W'(slot_ff) == fill_ff, "write slot out of step with fill count")
   // divider leaves after its last digit
   `AOSMA_ASSERT_NEXT(a_div_exit, clock, reset,
      state_ff == aosma_pkg::ST_DIV && dig_ff == DIG_W'(NDIG - 1),
      state_ff == aosma_pkg::ST_DONE, "divider overran")

endmodule

// ===== hw/rtl/aosma_scale.sv =====
// ----------------------------------------------------------------------------
// aosma_scale
// code times gain, rounded half up from q12.24 to q12.16
// ----------------------------------------------------------------------------
module aosma_scale (
   input  logic                              clock,
   input  logic                              load,
   input  logic [aosma_pkg::CODE_W-1:0]      code,
   input  logic [aosma_pkg::GAIN_W-1:0]      gain,
   output logic [aosma_pkg::SCALE_W-1:0]     scaled
);

   logic [aosma_pkg::PROD_W-1:0]  prod;
   logic [aosma_pkg::SCALE_W-1:0] scaled_in;
   logic [aosma_pkg::SCALE_W-1:0] scaled_ff;

   assign prod = aosma_pkg::PROD_W'(code) * aosma_pkg::PROD_W'(gain);

   // (p + 128) >> 8 is the top bits plus the first dropped bit
   assign scaled_in = prod[aosma_pkg::PROD_W-1:aosma_pkg::RND_SHIFT]
                    + aosma_pkg::SCALE_W'(prod[aosma_pkg::RND_SHIFT-1]);

   always_ff @(posedge clock) begin
      if (load) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

// ===== hw/rtl/aosma_lane.sv =====
// ----------------------------------------------------------------------------
// aosma_lane
// one channel: history window, running sum and rounded divide by fill count
// ----------------------------------------------------------------------------
module aosma_lane #(
   parameter int WINDOW_TAPS = aosma_pkg::WINDOW_TAPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  aosma_pkg::lane_ctl_type                ctl,
   input  logic signed [aosma_pkg::SAMPLE_W-1:0]  sample,
   input  logic [((WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1)-1:0] slot,
   input  logic                                   hist_live,
   input  logic [$clog2(WINDOW_TAPS+1)-1:0]       count,
   output aosma_pkg::lane_res_type                res
);

   localparam int CNT_W  = $clog2(WINDOW_TAPS + 1);
   localparam int SUM_W  = aosma_pkg::SAMPLE_W + $clog2(WINDOW_TAPS);
   localparam int NW     = SUM_W + 1;
   localparam int NDIG   = (NW + aosma_pkg::DIV_BITS - 1) / aosma_pkg::DIV_BITS;
   localparam int PW     = NDIG * aosma_pkg::DIV_BITS;

   logic signed [aosma_pkg::SAMPLE_W-1:0] hist_ff [WINDOW_TAPS];
   logic signed [aosma_pkg::SAMPLE_W-1:0] old_ff;
   logic signed [aosma_pkg::SAMPLE_W-1:0] samp_ff;
   logic signed [SUM_W-1:0]               sum_ff;
   logic signed [SUM_W-1:0]               sum_in;
   logic                                  neg_ff;
   logic [PW-1:0]                         num_ff;
   logic [PW-1:0]                         num_in;
   logic [CNT_W-1:0]                      rem_ff;
   logic [CNT_W-1:0]                      rem_in;
   logic signed [NW-1:0]                  sum_x;
   logic [NW-1:0]                         half_x;
   logic [NW-1:0]                         mag_x;
   logic [CNT_W-1:0]                      r_v;
   logic [PW-1:0]                         w_v;
   logic [CNT_W:0]                        t_v;

   // history slots not yet written since reset read as zero
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         old_ff <= hist_live ? hist_ff[slot] : '0;
      end
      if (ctl.sample) begin
         samp_ff <= sample;
      end
      if (ctl.accum) begin
         hist_ff[slot] <= samp_ff;
      end
   end

   assign sum_in = sum_ff + SUM_W'(samp_ff) - SUM_W'(old_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctl.accum) begin
         sum_ff <= sum_in;
      end
   end

   // magnitude plus half the divisor, negation folded into one adder
   assign sum_x  = NW'(sum_ff);
   assign half_x = NW'(count >> 1);
   assign mag_x  = sum_ff[SUM_W-1] ? (~sum_x + half_x + NW'(1)) : (sum_x + half_x);

   // restoring divide, DIV_BITS quotient bits a cycle, quotient shifts in at the bottom
   always_comb begin
      r_v = rem_ff;
      w_v = num_ff;
      t_v = '0;
      for (int i = 0; i < aosma_pkg::DIV_BITS; i++) begin
         t_v = {r_v, w_v[PW-1]};
         w_v = {w_v[PW-2:0], 1'b0};
         if (t_v >= {1'b0, count}) begin
            t_v    = t_v - {1'b0, count};
            w_v[0] = 1'b1;
         end
         r_v = t_v[CNT_W-1:0];
      end
      num_in = w_v;
      rem_in = r_v;
   end

   always_ff @(posedge clock) begin
      if (ctl.prep) begin
         neg_ff <= sum_ff[SUM_W-1];
         num_ff <= PW'(mag_x);
         rem_ff <= '0;
      end else if (ctl.div) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign res.neg = neg_ff;
   assign res.mag = num_ff[aosma_pkg::SAMPLE_W-1:0];

endmodule

// ===== hw/rtl/aosma_merge.sv =====
// ----------------------------------------------------------------------------
// aosma_merge
// applies lane signs, packs the six averages and holds the result register
// ----------------------------------------------------------------------------
module aosma_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  aosma_pkg::lane_res_type lane_res [aosma_pkg::NUM_CH],
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output aosma_pkg::rsp_type      rsp_data,
   output logic                    free
);

   logic signed [aosma_pkg::OUT_W-1:0] avg [aosma_pkg::NUM_CH];
   logic                               valid_ff;
   logic                               valid_in;
   aosma_pkg::rsp_type                 data_ff;
   aosma_pkg::rsp_type                 data_in;

   // averages stay inside the sample range, so they fit the 32-bit output without a clamp
   always_comb begin
      for (int k = 0; k < aosma_pkg::NUM_CH; k++) begin
         avg[k] = lane_res[k].neg ? -aosma_pkg::OUT_W'(lane_res[k].mag)
                                  :  aosma_pkg::OUT_W'(lane_res[k].mag);
      end
      data_in.volt_offset_avg = avg[aosma_pkg::CH_VOFF];
      data_in.volt_ac_avg     = avg[aosma_pkg::CH_VAC];
      data_in.volt_dc_avg     = avg[aosma_pkg::CH_VDC];
      data_in.curr_offset_avg = avg[aosma_pkg::CH_IOFF];
      data_in.curr_ac_avg     = avg[aosma_pkg::CH_IAC];
      data_in.curr_spare_avg  = avg[aosma_pkg::CH_ISP];
   end

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== tb/sv/adc_offset_scale_moving_average_tb.sv =====
// ----------------------------------------------------------------------------
// adc_offset_scale_moving_average_tb
// self-checking bench for the six-channel adc scaling and boxcar average block
// ----------------------------------------------------------------------------
// adc frames go in through a valid/stall channel and averaged Q15.16 frames come
// back one per item. A software copy of the scaling, offset correction and
// 5-tap running sum predicts every output frame; results are matched in order,
// field by field. The run walks through directed corner frames, then random
// frames under several gain settings, with random idle gaps on both sides.
// ----------------------------------------------------------------------------
module adc_offset_scale_moving_average_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import aosma_pkg::*;

   // register index with nothing behind it, writes must be dropped
   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam int TAPS          = WINDOW_TAPS_DEF;
   localparam int CODE_MAX      = (1 << CODE_W) - 1;
   localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
   localparam int SETTLE_CYCLES = 12;   // extra idle time once every result is back
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 170;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;

   // -------------------------------------------------------------------------
   // frame predictor and in-order store of expected averages
   // -------------------------------------------------------------------------
   class avg_scoreboard;
      logic [GAIN_W-1:0] ac_gain;
      logic [GAIN_W-1:0] dc_gain;
      logic [GAIN_W-1:0] curr_gain;
      longint            history [NUM_CH][TAPS];
      longint            run_sum [NUM_CH];
      int                slot;
      int                fill;
      rsp_type           expected_avgs [$];
      int                items_noted;
      int                results_checked;
      int                failures;

      function new();
         ac_gain         = AC_GAIN_RST;
         dc_gain         = DC_GAIN_RST;
         curr_gain       = CURR_GAIN_RST;
         slot            = 0;
         fill            = 0;
         items_noted     = 0;
         results_checked = 0;
         failures        = 0;
         foreach (run_sum[ch]) begin
            run_sum[ch] = 0;
            for (int t = 0; t < TAPS; t++) history[ch][t] = 0;
         end
      endfunction

      function void write_gain(logic [CSR_ADDR_W-1:0] addr, logic [GAIN_W-1:0] value);
         case (addr)
            CSR_AC_GAIN:   ac_gain   = value;
            CSR_DC_GAIN:   dc_gain   = value;
            CSR_CURR_GAIN: curr_gain = value;
            default: ;     // unmapped index, ignored
         endcase
      endfunction

      // code times Q0.24 gain, rounded half up to Q12.16
      function longint scale_code(logic [CODE_W-1:0] code, logic [GAIN_W-1:0] gain);
         longint c;
         longint g;
         c = code;
         g = gain;
         return (c * g + 128) >>> RND_SHIFT;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // nearest, ties away from zero
      function longint div_nearest(longint sum, int cnt);
         longint mag;
         longint q;
         mag = (sum < 0) ? -sum : sum;
         q   = (mag + cnt / 2) / cnt;
         return (sum < 0) ? -q : q;
      endfunction

      function int pending();
         return expected_avgs.size();
      endfunction

      function string field_label(int ch);
         case (ch)
            CH_VOFF: return "volt_offset_avg";
            CH_VAC:  return "volt_ac_avg";
            CH_VDC:  return "volt_dc_avg";
            CH_IOFF: return "curr_offset_avg";
            CH_IAC:  return "curr_ac_avg";
            default: return "curr_spare_avg";
         endcase
      endfunction

      function void note_input(req_type frame);
         logic [NUM_CH-1:0][CODE_W-1:0] code;
         logic [NUM_CH-1:0][OUT_W-1:0]  avg;
         longint v_off, v_ac, v_dc, i_off, i_ac, i_sp;
         longint smp [NUM_CH];
         longint q;
         code  = frame;
         // lane 0 sits in the top bits of the packed frame
         v_off = scale_code(code[NUM_CH-1-CH_VOFF], ac_gain);
         v_ac  = scale_code(code[NUM_CH-1-CH_VAC],  ac_gain);
         v_dc  = scale_code(code[NUM_CH-1-CH_VDC],  dc_gain);
         i_off = scale_code(code[NUM_CH-1-CH_IOFF], curr_gain);
         i_ac  = scale_code(code[NUM_CH-1-CH_IAC],  curr_gain);
         i_sp  = scale_code(code[NUM_CH-1-CH_ISP],  curr_gain);
         smp[CH_VOFF] = clamp32(v_off);
         smp[CH_VAC]  = clamp32(v_off - v_ac);
         smp[CH_VDC]  = clamp32(v_dc);
         smp[CH_IOFF] = clamp32(i_off);
         smp[CH_IAC]  = clamp32(i_ac - i_off);
         smp[CH_ISP]  = clamp32(i_sp - i_off);
         if (fill < TAPS) fill++;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            run_sum[ch]       = run_sum[ch] - history[ch][slot] + smp[ch];
            history[ch][slot] = smp[ch];
            q                 = clamp32(div_nearest(run_sum[ch], fill));
            avg[NUM_CH-1-ch]  = 32'(q);
         end
         slot = (slot + 1) % TAPS;
         expected_avgs.push_back(rsp_type'(avg));
         items_noted++;
      endfunction

      function void check_result(rsp_type actual);
         rsp_type                      exp_frame;
         logic [NUM_CH-1:0][OUT_W-1:0] a;
         logic [NUM_CH-1:0][OUT_W-1:0] e;
         if (expected_avgs.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: unexpected result frame %h", $realtime, actual);
            return;
         end
         exp_frame = expected_avgs.pop_front();
         a = actual;
         e = exp_frame;
         results_checked++;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            if (a[NUM_CH-1-ch] !== e[NUM_CH-1-ch]) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: result %0d %s expected %0d (%h) got %0d (%h)",
                     $realtime, results_checked, field_label(ch),
                     $signed(e[NUM_CH-1-ch]), e[NUM_CH-1-ch],
                     $signed(a[NUM_CH-1-ch]), a[NUM_CH-1-ch]);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // signals and block
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [GAIN_W-1:0]     csr_wdata;

   avg_scoreboard sb;
   bit            no_idle;     // when set, neither side inserts gaps
   int            csr_writes;
   int            gain_settings;

   adc_offset_scale_moving_average uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // result side: random stall stretches, one accepted frame per loop
   // -------------------------------------------------------------------------
   initial begin
      int hold;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 9);
         if (hold != 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // every accepted result goes straight to the checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // -------------------------------------------------------------------------
   // driver tasks, all entered and left just after a falling edge
   // -------------------------------------------------------------------------
   task automatic send_frame(req_type frame);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = frame;
      do @(posedge clock); while (req_stall);
      sb.note_input(frame);
      @(negedge clock);
   endtask

   // stop sending and let every outstanding frame come back
   task automatic drain_results();
      int waited;
      req_valid = 1'b0;
      waited    = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // only called with the block idle
   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [GAIN_W-1:0] value);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      sb.write_gain(addr, value);
      csr_writes++;
   endtask

   task automatic set_gains(logic [GAIN_W-1:0] ac, logic [GAIN_W-1:0] dc,
                            logic [GAIN_W-1:0] curr);
      drain_results();
      write_csr(CSR_AC_GAIN, ac);
      write_csr(CSR_DC_GAIN, dc);
      write_csr(CSR_CURR_GAIN, curr);
      gain_settings++;
   endtask

   function automatic req_type make_frame(int voff, int vac, int vdc,
                                          int ioff, int iac, int isp);
      return req_type'{CODE_W'(voff), CODE_W'(vac), CODE_W'(vdc),
                       CODE_W'(ioff), CODE_W'(iac), CODE_W'(isp)};
   endfunction

   // codes lean toward the rails so the difference channels hit their extremes
   function automatic int draw_code();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return CODE_MAX;
         2:       return $urandom_range(CODE_MAX - 5, CODE_MAX);
         3:       return $urandom_range(0, 5);
         default: return $urandom_range(0, CODE_MAX);
      endcase
   endfunction

   function automatic req_type draw_frame();
      return make_frame(draw_code(), draw_code(), draw_code(),
                        draw_code(), draw_code(), draw_code());
   endfunction

   function automatic logic [GAIN_W-1:0] draw_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return GAIN_MAX;
         2:       return GAIN_W'($urandom_range(0, 255));
         default: return GAIN_W'($urandom_range(0, int'(GAIN_MAX)));
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb            = new();
      no_idle       = 1'b0;
      csr_writes    = 0;
      gain_settings = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_we        = 1'b0;
      csr_addr      = '0;
      csr_wdata     = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // warm-up straight out of reset, default gains, count climbs 1..5
      send_frame(make_frame(0, 0, 0, 0, 0, 0));
      send_frame(make_frame(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX));
      send_frame(make_frame(CODE_MAX, 0, 0, 0, 0, 0));
      send_frame(make_frame(0, CODE_MAX, 0, 0, 0, 0));
      send_frame(make_frame(0, 0, CODE_MAX, CODE_MAX, 0, 0));
      send_frame(make_frame(0, 0, 0, 0, CODE_MAX, CODE_MAX));
      send_frame(make_frame('hAAA, 'hAAA, 'hAAA, 'hAAA, 'hAAA, 'hAAA));
      send_frame(make_frame('h555, 'h555, 'h555, 'h555, 'h555, 'h555));

      // full-scale gains: largest products and most negative differences
      set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
      send_frame(make_frame(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX));
      send_frame(make_frame(0, CODE_MAX, CODE_MAX, CODE_MAX, 0, 0));
      send_frame(make_frame(0, CODE_MAX, CODE_MAX, CODE_MAX, 0, 0));
      send_frame(make_frame(CODE_MAX, 0, 0, 0, CODE_MAX, CODE_MAX));
      send_frame(make_frame(0, CODE_MAX, 0, CODE_MAX, 0, 0));

      // zero ac and current gains wipe those channels; a write to the unmapped index changes nothing
      set_gains('0, GAIN_MAX, '0);
      write_csr(CSR_UNMAPPED, GAIN_MAX);
      send_frame(make_frame(CODE_MAX, 0, CODE_MAX, CODE_MAX, 0, CODE_MAX));
      send_frame(make_frame(CODE_MAX, CODE_MAX, CODE_MAX, 0, CODE_MAX, 0));
      send_frame(make_frame(1, 1, 1, 1, 1, 1));

      // random frames under a different gain setting each phase
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
            1:       set_gains('0, draw_gain(), '0);
            3:       set_gains(AC_GAIN_RST, DC_GAIN_RST, CURR_GAIN_RST);
            5:       set_gains(GAIN_W'($urandom_range(0, 255)),
                               GAIN_W'($urandom_range(0, 255)),
                               GAIN_W'($urandom_range(0, 255)));
            default: set_gains(draw_gain(), draw_gain(), draw_gain());
         endcase
         if ($urandom_range(0, 1) == 1) write_csr(CSR_UNMAPPED, draw_gain());
         no_idle = (phase == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off mid-phase until the pipe is empty
            if (n == PHASE_ITEMS / 2) drain_results();
            // short bursts with no gaps in the other phases too
            if (phase != 4 && n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
            send_frame(draw_frame());
         end
      end
      no_idle = 1'b0;

      drain_results();
      if (sb.pending() != 0) begin
         $display("%0d expected result frames never arrived", sb.pending());
         sb.failures += sb.pending();
      end

      $display("sent %0d adc frames and checked %0d averaged frames", sb.items_noted,
               sb.results_checked);
      $display("%0d register writes across %0d gain settings, %0d failures", csr_writes,
               gain_settings, sb.failures);
      if (sb.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
